// ----- hw/rtl/klift_pkg.sv -----
package klift_pkg;

  localparam int NODE_W         = 10;
  localparam int STEP_W         = 10;
  localparam int NODE_COUNT_DEF = 1024;
  localparam int LEVELS_DEF     = 10;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [0:0] REG_NODE_COUNT = 1'd0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1);

  typedef struct packed {
    logic [1:0]        command;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent_node;
    logic [STEP_W-1:0] steps;
  } in_req_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] ancestor;
  } out_res_t;

  // node number is usable: not the root marker and inside the table
  function automatic logic node_ok(input logic [NODE_W-1:0] v, input int unsigned lim);
    node_ok = (v != '0) && (32'(v) < lim);
  endfunction

endpackage

// ----- hw/rtl/klift_mem.sv -----
module klift_mem import klift_pkg::*; #(
  parameter int AW    = 14,
  parameter int DEPTH = 10240
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [NODE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [NODE_W-1:0] wr_data
);

  logic [NODE_W-1:0] mem [0:DEPTH-1];
  logic [NODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/klift_ctrl.sv -----
module klift_ctrl import klift_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int LEVELS     = LEVELS_DEF,
  parameter int NW         = $clog2(NODE_COUNT),
  parameter int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_valid,
  output out_res_t          out_res,
  input  logic [NODE_W-1:0] node_count,
  output logic              rd_en,
  output logic [LW+NW-1:0]  rd_addr,
  input  logic [NODE_W-1:0] rd_data,
  output logic              wr_en,
  output logic [LW+NW-1:0]  wr_addr,
  output logic [NODE_W-1:0] wr_data
);

  localparam int JW = $clog2(STEP_W + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BRD1  = 6'b000010,
    ST_BRD2  = 6'b000100,
    ST_BWR   = 6'b001000,
    ST_QSCAN = 6'b010000,
    ST_QWAIT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     blvl_r, blvl_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;
  logic [NODE_W-1:0] last_r, last_nxt;
  logic              mid_ok_r, mid_ok_nxt;
  logic [JW-1:0]     qj_r, qj_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic              accept;
  logic [NODE_W-1:0] last_calc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // build covers nodes 1 to min(node_count, NODE_COUNT-1)
  assign last_calc = (32'(node_count) > NODE_COUNT - 1) ? NODE_W'(NODE_COUNT - 1) : node_count;

  always_comb begin
    state_nxt     = state_r;
    blvl_nxt      = blvl_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    mid_ok_nxt    = mid_ok_r;
    qj_nxt        = qj_r;
    steps_nxt     = steps_r;
    cur_nxt       = cur_r;
    ok_nxt        = ok_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.command)
            CMD_LOAD: begin
              if (node_ok(in_req.node, NODE_COUNT)) begin
                wr_en   = 1'b1;
                wr_addr = {LW'(0), NW'(in_req.node)};
                wr_data = in_req.parent_node;
              end
            end
            CMD_BUILD: begin
              last_nxt = last_calc;
              blvl_nxt = LW'(1);
              v_nxt    = NODE_W'(1);
              if (last_calc != '0 && LEVELS > 1) begin
                state_nxt = ST_BRD1;
              end
            end
            CMD_QUERY: begin
              qj_nxt    = '0;
              steps_nxt = in_req.steps;
              cur_nxt   = in_req.node;
              ok_nxt    = node_ok(in_req.node, NODE_COUNT);
              state_nxt = ST_QSCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BRD1: begin
        rd_en     = 1'b1;
        rd_addr   = {blvl_r - LW'(1), NW'(v_r)};
        state_nxt = ST_BRD2;
      end
      ST_BRD2: begin
        // rd_data is the 2^(j-1) ancestor, now fetch its own 2^(j-1) ancestor
        rd_en      = 1'b1;
        rd_addr    = {blvl_r - LW'(1), NW'(rd_data)};
        mid_ok_nxt = node_ok(rd_data, NODE_COUNT);
        state_nxt  = ST_BWR;
      end
      ST_BWR: begin
        wr_en   = 1'b1;
        wr_addr = {blvl_r, NW'(v_r)};
        wr_data = mid_ok_r ? rd_data : '0;
        if (v_r == last_r) begin
          v_nxt = NODE_W'(1);
          if (32'(blvl_r) == LEVELS - 1) begin
            state_nxt = ST_IDLE;
          end else begin
            blvl_nxt  = blvl_r + LW'(1);
            state_nxt = ST_BRD1;
          end
        end else begin
          v_nxt     = v_r + NODE_W'(1);
          state_nxt = ST_BRD1;
        end
      end
      ST_QSCAN: begin
        if (!ok_r || 32'(qj_r) == STEP_W) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.found    = ok_r;
          out_res_nxt.ancestor = ok_r ? cur_r : '0;
          state_nxt            = ST_IDLE;
        end else if (!steps_r[qj_r[JW-1:0]]) begin
          qj_nxt = qj_r + JW'(1);
        end else if (32'(qj_r) >= LEVELS) begin
          ok_nxt = 1'b0;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = {LW'(qj_r), NW'(cur_r)};
          state_nxt = ST_QWAIT;
        end
      end
      ST_QWAIT: begin
        cur_nxt   = rd_data;
        ok_nxt    = node_ok(rd_data, NODE_COUNT);
        qj_nxt    = qj_r + JW'(1);
        state_nxt = ST_QSCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blvl_r    <= blvl_nxt;
    v_r       <= v_nxt;
    last_r    <= last_nxt;
    mid_ok_r  <= mid_ok_nxt;
    qj_r      <= qj_nxt;
    steps_r   <= steps_nxt;
    cur_r     <= cur_nxt;
    ok_r      <= ok_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_QSCAN))
    else $error("result strobe without a finished query");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && rd_addr == wr_addr))
    else $error("read and write of one table entry in the same cycle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while still busy");

  a_build_not_level0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BWR) |-> (blvl_r != '0))
    else $error("build pass writing the parent level");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.found) |-> (out_res_r.ancestor != '0))
    else $error("found ancestor is the root marker");

endmodule

// ----- hw/rtl/kth_ancestor_lifting_engine.sv -----
// channel   ports                               handshake
// request   start, busy, in_req                 taken when start && !busy
// result    out_valid, out_res                  one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr,       apb, pready tied high
//           pwdata, prdata, pready
//
// load: the entry is written as the request is taken, busy stays low. query: scans the
// steps bits in order and reads the table once per set bit (one hop), waiting for the
// registered read data; the scan stops at the first missing ancestor.
// build: walks levels 1 to LEVELS-1 and, per level, nodes 1 to min(node_count, NODE_COUNT-1),
// with two dependent table reads and a write back per entry.
// reset (rst_n low, synchronous) returns to idle and keeps node_count at 1; the table
// is not cleared. the result side cannot stall.
module kth_ancestor_lifting_engine import klift_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int LEVELS     = LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH = LEVELS * (2 ** NW);

  logic [NODE_W-1:0] node_count_r;
  logic              rd_en, wr_en;
  logic [LW+NW-1:0]  rd_addr, wr_addr;
  logic [NODE_W-1:0] rd_data, wr_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
      node_count_r <= pwdata[NODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-NODE_W){1'b0}}, node_count_r} : '0;

  klift_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .LEVELS     (LEVELS),
    .NW         (NW),
    .LW         (LW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .node_count (node_count_r),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  klift_mem #(
    .AW    (LW + NW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
